// ===== src/lla_pkg.sv =====
// Shared types and constants for the life-like automaton step block.
package lla_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int MASK_W = 9;
	localparam int SIZE_W = 7;
	localparam int CFG_IDX_W = 8;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_ADVANCE = 2'd2
	} lla_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_USED    = 8'd0,
		CFG_COLS_USED    = 8'd1,
		CFG_BORN_MASK    = 8'd2,
		CFG_SURVIVE_MASK = 8'd3
	} lla_cfg_idx_t;

	localparam logic [SIZE_W-1:0] ROWS_USED_RST    = 7'd64;
	localparam logic [SIZE_W-1:0] COLS_USED_RST    = 7'd64;
	localparam logic [MASK_W-1:0] BORN_MASK_RST    = 9'd8;
	localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd12;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_ADV
	} lla_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] row;
		logic [5:0] col;
		logic       value;
	} lla_req_t;

	typedef struct packed {
		logic cell_value;
		logic generation_done;
	} lla_rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [MASK_W-1:0]    data;
	} lla_cfg_t;

endpackage

// ===== src/lla_chan_if.sv =====
// Valid/ready channel carrying one payload per transfer.
interface lla_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/life_like_automaton_step.sv =====
// Top level of the life-like automaton step block: grid memory, sequencer and result register.
//
// The grid is held in one row-wide synchronous memory, one word per row. After reset a
// clearing pass writes MAX_ROWS rows, one per cycle, and no command is taken until it
// ends; configuration writes are taken at any time. A cell write or read is a transfer
// plus one row read; a write puts the modified row back. In an advance the memory read
// port delivers one row per cycle, the new row is written back as soon as the rows on
// both sides are on hand, and the first and last rows are kept in registers for the
// wrap. A result waits in an output register; the next command is taken meanwhile and
// holds in its last cycle until the output frees up.
module life_like_automaton_step #(
	parameter int MAX_ROWS = lla_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lla_pkg::MAX_COLS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	lla_chan_if.sink     req,
	lla_chan_if.source   rsp,
	lla_chan_if.sink     cfg
);
	import lla_pkg::*;

	localparam int RA  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SW  = $clog2(MAX_ROWS + 3);
	localparam int NCW = $clog2(MAX_COLS + 1);

	function automatic logic [SW-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
		if (32'(v) < 3) return SW'(3);
		if (32'(v) > MAX_ROWS) return SW'(MAX_ROWS);
		return SW'(v);
	endfunction

	function automatic logic [NCW-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
		if (32'(v) < 3) return NCW'(3);
		if (32'(v) > MAX_COLS) return NCW'(MAX_COLS);
		return NCW'(v);
	endfunction

	// grid memory
	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rdata_q;
	logic                mem_we;
	logic                mem_re;
	logic [RA-1:0]       mem_waddr;
	logic [RA-1:0]       mem_raddr;
	logic [MAX_COLS-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= grid_mem[mem_raddr];
	end

	// configuration, kept in clamped form
	logic [SW-1:0]     eff_rows_q;
	logic [NCW-1:0]    eff_cols_q;
	logic [MASK_W-1:0] born_q;
	logic [MASK_W-1:0] survive_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_rows_q <= clamp_rows(ROWS_USED_RST);
			eff_cols_q <= clamp_cols(COLS_USED_RST);
			born_q     <= BORN_MASK_RST;
			survive_q  <= SURVIVE_MASK_RST;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				CFG_ROWS_USED:    eff_rows_q <= clamp_rows(cfg.payload.data[SIZE_W-1:0]);
				CFG_COLS_USED:    eff_cols_q <= clamp_cols(cfg.payload.data[SIZE_W-1:0]);
				CFG_BORN_MASK:    born_q <= cfg.payload.data;
				CFG_SURVIVE_MASK: survive_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	// control state
	lla_state_t    state_q, state_d;
	logic [RA-1:0] clr_q, clr_d;
	logic [SW-1:0] step_q, step_d;
	logic          rsp_valid_q;
	lla_rsp_t      rsp_q;
	logic          load_rsp;
	lla_rsp_t      rsp_d;
	logic          take_req;
	logic          adv_go;

	// captured command
	logic [1:0]    cmd_q;
	logic [RA-1:0] row_q;
	logic [CA-1:0] col_q;
	logic          val_q;
	logic          inside_q;
	logic          req_inside;

	// row window for the advance sweep
	logic [MAX_COLS-1:0] up_q, cur_q, last_q, first_q;
	logic [MAX_COLS-1:0] dn_row;
	logic [MAX_COLS-1:0] new_row;
	logic [CA-1:0]       nc_m1;
	logic                out_free;
	logic                adv_final;

	assign nc_m1 = CA'(eff_cols_q - NCW'(1));
	assign out_free = !rsp_valid_q || rsp.ready;
	assign adv_final = (step_q == eff_rows_q + SW'(2));
	assign req_inside = (32'(req.payload.row) < MAX_ROWS) && (32'(req.payload.col) < MAX_COLS);

	always_comb begin
		if (step_q == eff_rows_q + SW'(1)) dn_row = last_q;
		else if (adv_final) dn_row = first_q;
		else dn_row = rdata_q;
	end

	lla_row_calc #(
		.MAX_COLS(MAX_COLS)
	) u_row_calc (
		.up          (up_q),
		.cur         (cur_q),
		.dn          (dn_row),
		.nc_m1       (nc_m1),
		.born_mask   (born_q),
		.survive_mask(survive_q),
		.new_row     (new_row)
	);

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		step_d    = step_q;
		req.ready = 1'b0;
		take_req  = 1'b0;
		adv_go    = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		mem_wdata = '0;
		load_rsp  = 1'b0;
		rsp_d     = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + RA'(1);
				if (32'(clr_q) == MAX_ROWS - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					take_req = 1'b1;
					if (req.payload.command == CMD_ADVANCE) begin
						step_d  = '0;
						state_d = ST_ADV;
					end else begin
						mem_re    = req_inside;
						mem_raddr = RA'(req.payload.row);
						state_d   = ST_CELL;
					end
				end
			end
			ST_CELL: begin
				if (out_free) begin
					load_rsp = 1'b1;
					rsp_d.cell_value = (cmd_q == CMD_READ) && inside_q && rdata_q[col_q];
					if ((cmd_q == CMD_WRITE) && inside_q) begin
						mem_we         = 1'b1;
						mem_waddr      = row_q;
						mem_wdata      = rdata_q;
						mem_wdata[col_q] = val_q;
					end
					state_d = ST_IDLE;
				end
			end
			ST_ADV: begin
				// read order: last row first, then rows 0 .. rows-2
				mem_re    = (step_q < eff_rows_q);
				mem_raddr = (step_q == '0) ? RA'(eff_rows_q - SW'(1)) : RA'(step_q - SW'(1));
				if (!adv_final || out_free) begin
					adv_go = 1'b1;
					step_d = step_q + SW'(1);
					if (step_q >= SW'(3)) begin
						mem_we    = 1'b1;
						mem_waddr = RA'(step_q - SW'(3));
						mem_wdata = new_row;
					end
					if (adv_final) begin
						load_rsp = 1'b1;
						rsp_d.generation_done = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			step_q  <= step_d;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) rsp_q <= rsp_d;
		if (take_req) begin
			cmd_q    <= req.payload.command;
			row_q    <= RA'(req.payload.row);
			col_q    <= CA'(req.payload.col);
			val_q    <= req.payload.value;
			inside_q <= req_inside;
		end
		if (adv_go) begin
			if (step_q == SW'(1)) begin
				last_q <= rdata_q;
				up_q   <= rdata_q;
			end else if (step_q == SW'(2)) begin
				cur_q   <= rdata_q;
				first_q <= rdata_q;
			end else if (step_q >= SW'(3)) begin
				up_q  <= cur_q;
				cur_q <= dn_row;
			end
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

// ===== src/lla_row_calc.sv =====
// Next-generation value of one grid row from the old rows above, at and below it.
module lla_row_calc #(
	parameter int MAX_COLS = lla_pkg::MAX_COLS_DEF,
	localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic [MAX_COLS-1:0]        up,
	input  logic [MAX_COLS-1:0]        cur,
	input  logic [MAX_COLS-1:0]        dn,
	input  logic [CA-1:0]              nc_m1,
	input  logic [lla_pkg::MASK_W-1:0] born_mask,
	input  logic [lla_pkg::MASK_W-1:0] survive_mask,
	output logic [MAX_COLS-1:0]        new_row
);
	import lla_pkg::*;

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
		logic [2:0] lf;
		logic [2:0] rt;
		logic [7:0] nb;
		logic [3:0] cnt;
		logic       in_use;

		// left neighbor of column 0 wraps to the last column in use
		if (c == 0) begin : g_lf_wrap
			assign lf = {up[nc_m1], cur[nc_m1], dn[nc_m1]};
		end else begin : g_lf
			assign lf = {up[c-1], cur[c-1], dn[c-1]};
		end

		if (c == MAX_COLS - 1) begin : g_rt_wrap
			assign rt = {up[0], cur[0], dn[0]};
		end else begin : g_rt
			assign rt = (CA'(c) == nc_m1) ? {up[0], cur[0], dn[0]}
			                              : {up[c+1], cur[c+1], dn[c+1]};
		end

		assign nb = {lf, rt, up[c], dn[c]};
		assign cnt = 4'($countones(nb));
		assign in_use = (CA'(c) <= nc_m1);
		assign new_row[c] = in_use ? (cur[c] ? survive_mask[cnt] : born_mask[cnt]) : cur[c];
	end

endmodule
